>>> sv/i2p_pkg.sv
`default_nettype none

package i2p_pkg;

  localparam int STACK_DEPTH_DEF = 32;

  localparam logic [7:0] CH_OPEN  = 8'h28;  // '('
  localparam logic [7:0] CH_CLOSE = 8'h29;  // ')'
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_CARET = 8'h5e;
  localparam logic [7:0] CH_UPPER_LO = 8'd64;
  localparam logic [7:0] CH_UPPER_HI = 8'd91;
  localparam logic [7:0] CH_LOWER_LO = 8'd96;
  localparam logic [7:0] CH_LOWER_HI = 8'd123;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_BAD_CHAR   = 2'd1,
    STAT_UNBALANCED = 2'd2,
    STAT_OVERFLOW   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OPER,
    ST_CLOSE,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
  } in_req_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       has_symbol;
    status_t    status;
    logic       last;
  } out_res_t;

  // Stack move applied to every cell of the chain in the same cycle.
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

  function automatic logic [1:0] char_level(input logic [7:0] c);
    logic [1:0] lvl;
    lvl = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) lvl = 2'd1;
    else if (c == CH_STAR || c == CH_SLASH) lvl = 2'd2;
    else if (c == CH_CARET) lvl = 2'd3;
    return lvl;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c > CH_UPPER_LO && c < CH_UPPER_HI) ||
           (c > CH_LOWER_LO && c < CH_LOWER_HI);
  endfunction

endpackage

`default_nettype wire

>>> sv/infix_to_postfix_converter.sv
// Infix to postfix converter (shunting yard), one character per request.
// in_data carries kind (0 character, 1 end of expression) and ch. out_data
// carries symbol, has_symbol, status and last; last marks the closing result
// of an expression (end flush or error).
// The stack is a chain of cells that shifts one entry per cycle, and each
// pop other than of a matching '(' fills the one output register. A letter,
// '(' or an error found at acceptance is handled when it is accepted. An
// operator is taken, then pops the entries it must one at a time, then is
// pushed or reports an overflow. ')' pops the entries down to and including
// its '(', and the end marker pops every stacked entry before its closing
// result. A letter or error result appears on out_valid the cycle after the
// request is accepted; a popped operator appears the cycle after its pop.
// in_ready drops while a pop sequence runs.
// Reset (synchronous, rst high) empties the stack, clears the error-discard
// mode and drops out_valid; no clearing pass is needed.
// When out_ready is low the held result stays in the output register and
// all work stops until it is taken; a new request is still taken if the
// output register is empty or being emptied in the same cycle.
`default_nettype none

module infix_to_postfix_converter
  import i2p_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire in_req_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output out_res_t     out_data
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE   = CW'(1);

  state_t          state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   opens, opens_next;
  logic            discarding, discarding_next;
  logic [7:0]      pend_op, pend_op_next;

  stk_ctl_t        ctl;
  logic [7:0]      push_data;
  logic [7:0]      top;
  logic [1:0]      top_level;
  logic [1:0]      pend_level;
  logic            full;
  logic            can_emit;
  logic            accept;
  logic            emit;
  out_res_t        emit_res;

  i2p_op_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
    .clk       (clk),
    .ctl       (ctl),
    .push_data (push_data),
    .top       (top)
  );

  assign can_emit   = !out_valid || out_ready;
  assign in_ready   = (state == ST_IDLE) && can_emit;
  assign accept     = in_valid && in_ready;
  assign full       = (count == DEPTH);
  assign top_level  = (count != '0) ? char_level(top) : 2'd0;
  assign pend_level = char_level(pend_op);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && !discarding) begin
          if (in_data.kind) begin
            if (opens == '0) state_next = ST_FLUSH;
          end else if (in_data.ch == CH_CLOSE) begin
            if (opens != '0) state_next = ST_CLOSE;
          end else if (char_level(in_data.ch) != 2'd0) begin
            state_next = ST_OPER;
          end
        end
      end
      ST_OPER: begin
        if (can_emit && !(count != '0 && pend_level <= top_level)) state_next = ST_IDLE;
      end
      ST_CLOSE: begin
        if (can_emit && top == CH_OPEN) state_next = ST_IDLE;
      end
      ST_FLUSH: begin
        if (can_emit && count == '0) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl             = '0;
    push_data       = in_data.ch;
    count_next      = count;
    opens_next      = opens;
    discarding_next = discarding;
    pend_op_next    = pend_op;
    emit            = 1'b0;
    emit_res        = '{symbol: 8'd0, has_symbol: 1'b0, status: STAT_OK, last: 1'b0};
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.kind) begin
            if (discarding) begin
              count_next      = '0;
              opens_next      = '0;
              discarding_next = 1'b0;
            end else if (opens != '0) begin
              emit            = 1'b1;
              emit_res.status = STAT_UNBALANCED;
              emit_res.last   = 1'b1;
              count_next      = '0;
              opens_next      = '0;
            end
          end else if (!discarding) begin
            if (is_letter(in_data.ch)) begin
              emit                = 1'b1;
              emit_res.symbol     = in_data.ch;
              emit_res.has_symbol = 1'b1;
            end else if (in_data.ch == CH_OPEN) begin
              if (full) begin
                emit            = 1'b1;
                emit_res.status = STAT_OVERFLOW;
                emit_res.last   = 1'b1;
                count_next      = '0;
                opens_next      = '0;
                discarding_next = 1'b1;
              end else begin
                ctl.push   = 1'b1;
                count_next = count + ONE;
                opens_next = opens + ONE;
              end
            end else if (in_data.ch == CH_CLOSE) begin
              if (opens == '0) begin
                emit            = 1'b1;
                emit_res.status = STAT_UNBALANCED;
                emit_res.last   = 1'b1;
                count_next      = '0;
                discarding_next = 1'b1;
              end
            end else if (char_level(in_data.ch) != 2'd0) begin
              pend_op_next = in_data.ch;
            end else begin
              emit            = 1'b1;
              emit_res.status = STAT_BAD_CHAR;
              emit_res.last   = 1'b1;
              count_next      = '0;
              opens_next      = '0;
              discarding_next = 1'b1;
            end
          end
        end
      end
      ST_OPER: begin
        if (can_emit) begin
          if (count != '0 && pend_level <= top_level) begin
            emit                = 1'b1;
            emit_res.symbol     = top;
            emit_res.has_symbol = 1'b1;
            ctl.pop             = 1'b1;
            count_next          = count - ONE;
          end else if (full) begin
            emit            = 1'b1;
            emit_res.status = STAT_OVERFLOW;
            emit_res.last   = 1'b1;
            count_next      = '0;
            opens_next      = '0;
            discarding_next = 1'b1;
          end else begin
            ctl.push   = 1'b1;
            push_data  = pend_op;
            count_next = count + ONE;
          end
        end
      end
      ST_CLOSE: begin
        if (can_emit) begin
          ctl.pop    = 1'b1;
          count_next = count - ONE;
          if (top != CH_OPEN) begin
            emit                = 1'b1;
            emit_res.symbol     = top;
            emit_res.has_symbol = 1'b1;
          end else begin
            // drop the matching open paren
            opens_next = opens - ONE;
          end
        end
      end
      ST_FLUSH: begin
        if (can_emit) begin
          emit = 1'b1;
          if (count != '0) begin
            emit_res.symbol     = top;
            emit_res.has_symbol = 1'b1;
            ctl.pop             = 1'b1;
            count_next          = count - ONE;
          end else begin
            emit_res.last = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      opens      <= '0;
      discarding <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      opens      <= opens_next;
      discarding <= discarding_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_op <= pend_op_next;
    if (emit) begin
      out_data <= emit_res;
    end
  end

endmodule

`default_nettype wire

>>> sv/i2p_stack_cell.sv
`default_nettype none

module i2p_stack_cell
  import i2p_pkg::*;
(
  input  wire logic       clk,
  input  wire stk_ctl_t   ctl,
  input  wire logic [7:0] from_above,
  input  wire logic [7:0] from_below,
  output logic [7:0]      entry
);

  // Push takes the neighbor above, pop takes the neighbor below.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      entry <= from_above;
    end else if (ctl.pop) begin
      entry <= from_below;
    end
  end

endmodule

`default_nettype wire

>>> sv/i2p_op_stack.sv
`default_nettype none

module i2p_op_stack
  import i2p_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic       clk,
  input  stk_ctl_t        ctl,
  input  wire logic [7:0] push_data,
  output logic [7:0]      top
);

  logic [7:0] entries [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [7:0] above;
    logic [7:0] below;
    if (i == 0) begin : g_head
      assign above = push_data;
    end else begin : g_body
      assign above = entries[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_tail
      assign below = entries[i];
    end else begin : g_link
      assign below = entries[i+1];
    end
    i2p_stack_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .from_above (above),
      .from_below (below),
      .entry      (entries[i])
    );
  end

  assign top = entries[0];

endmodule

`default_nettype wire

>>> sv/i2p_checker.sv
`default_nettype none

module i2p_checker
  import i2p_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire out_res_t out_data
);

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Error results always close the expression.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != STAT_OK |-> out_data.last && !out_data.has_symbol)
    else $error("error result not final");

  // Symbols never carry an error or the closing flag.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.has_symbol |-> !out_data.last && out_data.status == STAT_OK)
    else $error("symbol result flagged final");

  // A result without a symbol is always the closing one.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.has_symbol |-> out_data.last)
    else $error("empty result not final");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

>>> sim/tb_top.sv
module tb_top
  import i2p_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET  = 430;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 80;

  // Tracks the operator stack the block should hold and the postfix
  // characters it should emit, in order.
  class postfix_scoreboard;
    logic [7:0] op_stack [STACK_DEPTH_DEF];
    logic [5:0] stack_count;
    logic [2:0] current_level;
    bit         discarding;
    out_res_t   pending_q[$];
    int         errors;
    int         checked;
    int         live_items;
    int         by_status [4];

    function new();
      clear();
      errors     = 0;
      checked    = 0;
      live_items = 0;
      foreach (by_status[i]) by_status[i] = 0;
    endfunction

    function void clear();
      stack_count   = '0;
      current_level = '0;
      discarding    = 1'b0;
    endfunction

    function logic [2:0] prec(logic [7:0] c);
      case (c)
        CH_PLUS, CH_MINUS: return 3'd1;
        CH_STAR, CH_SLASH: return 3'd2;
        CH_CARET:          return 3'd3;
        default:           return 3'd0;
      endcase
    endfunction

    // A-Z and a-z
    function bit letter(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
    endfunction

    function bit open_held();
      for (int i = 0; i < stack_count; i++)
        if (op_stack[i] == CH_OPEN) return 1'b1;
      return 1'b0;
    endfunction

    function logic [2:0] top_prec();
      if (stack_count == 0) return 3'd0;
      return prec(op_stack[stack_count - 1]);
    endfunction

    function void add(logic [7:0] sym, bit has, status_t st, bit last);
      out_res_t r;
      r.symbol     = sym;
      r.has_symbol = has;
      r.status     = st;
      r.last       = last;
      pending_q.push_back(r);
    endfunction

    function void pop_emit();
      stack_count = stack_count - 6'd1;
      add(op_stack[stack_count], 1'b1, STAT_OK, 1'b0);
    endfunction

    function void abort(status_t code);
      clear();
      discarding = 1'b1;
      add(8'h00, 1'b0, code, 1'b1);
    endfunction

    function void note_request(in_req_t r);
      logic [2:0] p;
      if (r.kind) begin
        if (discarding) begin
          clear();
          return;
        end
        live_items++;
        if (open_held()) begin
          clear();
          add(8'h00, 1'b0, STAT_UNBALANCED, 1'b1);
          return;
        end
        while (stack_count != 0) pop_emit();
        add(8'h00, 1'b0, STAT_OK, 1'b1);
        clear();
        return;
      end
      if (discarding) return;
      live_items++;
      if (letter(r.ch)) begin
        add(r.ch, 1'b1, STAT_OK, 1'b0);
        return;
      end
      if (r.ch == CH_OPEN) begin
        if (stack_count >= STACK_DEPTH_DEF) begin
          abort(STAT_OVERFLOW);
          return;
        end
        op_stack[stack_count] = r.ch;
        stack_count   = stack_count + 6'd1;
        current_level = 3'd0;
        return;
      end
      if (r.ch == CH_CLOSE) begin
        if (!open_held()) begin
          abort(STAT_UNBALANCED);
          return;
        end
        while (op_stack[stack_count - 1] != CH_OPEN) pop_emit();
        // drop the matching open paren
        stack_count   = stack_count - 6'd1;
        current_level = top_prec();
        return;
      end
      p = prec(r.ch);
      if (p == 3'd0) begin
        abort(STAT_BAD_CHAR);
        return;
      end
      while (stack_count != 0 && p <= current_level) begin
        pop_emit();
        current_level = top_prec();
      end
      if (stack_count >= STACK_DEPTH_DEF) begin
        abort(STAT_OVERFLOW);
        return;
      end
      op_stack[stack_count] = r.ch;
      stack_count   = stack_count + 6'd1;
      current_level = p;
    endfunction

    task check_result(out_res_t got);
      out_res_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result: symbol %h has %b status %0d last %b",
                         got.symbol, got.has_symbol, got.status, got.last));
        return;
      end
      want = pending_q.pop_front();
      checked++;
      by_status[want.status]++;
      if (got.symbol !== want.symbol)
        report($sformatf("result %0d: symbol %h, want %h", checked, got.symbol,
                         want.symbol));
      if (got.has_symbol !== want.has_symbol)
        report($sformatf("result %0d: has_symbol %b, want %b", checked,
                         got.has_symbol, want.has_symbol));
      if (got.status !== want.status)
        report($sformatf("result %0d: status %0d, want %0d", checked, got.status,
                         want.status));
      if (got.last !== want.last)
        report($sformatf("result %0d: last %b, want %b", checked, got.last,
                         want.last));
    endtask

    task report(string what);
      errors++;
      if (errors <= 30) $display("error: %s", what);
    endtask
  endclass

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  in_req_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_res_t out_data;

  postfix_scoreboard sb = new();
  in_req_t script[$];
  bit      steady = 1'b0;
  int      requests_sent = 0;
  int      idle_cycles = 0;

  infix_to_postfix_converter DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly no gap, some short ones, a few long ones.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(9, 40);
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1) != 0) return 8'h41 + 8'($urandom_range(0, 25));
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 4))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      default: return CH_CARET;
    endcase
  endfunction

  function automatic void push_char(logic [7:0] c);
    in_req_t r;
    r.kind = 1'b0;
    r.ch   = c;
    script.push_back(r);
  endfunction

  // ch is a don't-care on the end marker; randomize it anyway.
  function automatic void push_end();
    in_req_t r;
    r.kind = 1'b1;
    r.ch   = 8'($urandom_range(0, 255));
    script.push_back(r);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endfunction

  function automatic void build_expr();
    int terms;
    int open_n;
    terms  = $urandom_range(1, 8);
    open_n = 0;
    for (int i = 0; i < terms; i++) begin
      while (open_n < 4 && $urandom_range(0, 3) == 0) begin
        push_char(CH_OPEN);
        open_n++;
      end
      push_char(rand_letter());
      while (open_n > 0 && $urandom_range(0, 2) == 0) begin
        push_char(CH_CLOSE);
        open_n--;
      end
      if (i != terms - 1) push_char(rand_op());
    end
    repeat (open_n) push_char(CH_CLOSE);
    push_end();
  endfunction

  // Well-formed expression with one or two edits before its end marker.
  function automatic void build_broken();
    int at;
    int edits;
    build_expr();
    void'(script.pop_back());
    edits = $urandom_range(1, 2);
    repeat (edits) begin
      at = (script.size() == 0) ? 0 : $urandom_range(0, script.size() - 1);
      case ($urandom_range(0, 3))
        0: if (script.size() != 0) script[at].ch = 8'($urandom_range(0, 255));
        1: if (script.size() != 0) script.delete(at);
        2: script.insert(at, '{kind: 1'b0, ch: CH_CLOSE});
        default: script.insert(at, '{kind: 1'b0, ch: CH_OPEN});
      endcase
    end
    push_end();
  endfunction

  // Deep nesting to reach a full stack; close count exact or off by one either way.
  function automatic void build_nested();
    int depth;
    int closes;
    depth = $urandom_range(8, 34);
    repeat (depth) begin
      push_char(CH_OPEN);
      if ($urandom_range(0, 1) != 0) begin
        push_char(rand_letter());
        push_char(rand_op());
      end
    end
    push_char(rand_letter());
    closes = depth - 1 + $urandom_range(0, 2);
    repeat (closes) push_char(CH_CLOSE);
    push_end();
  endfunction

  function automatic void build_noise();
    in_req_t r;
    repeat ($urandom_range(1, 6)) begin
      r.kind = 1'($urandom_range(0, 9) == 0);
      r.ch   = 8'($urandom_range(0, 255));
      script.push_back(r);
    end
    if ($urandom_range(0, 1) != 0) push_end();
  endfunction

  task automatic send_item(in_req_t r);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    sb.note_request(r);
    requests_sent++;
  endtask

  task automatic run_script();
    while (script.size() != 0) send_item(script.pop_front());
  endtask

  initial begin
    int stall;
    forever begin
      stall = pick_gap();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(negedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: %0d cycles without a handshake, %0d results outstanding",
               idle_cycles, sb.pending_q.size());
      $display("infix_to_postfix_converter: mismatch");
      $finish;
    end
  end

  initial begin
    int exprs;
    int pick;
    exprs = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    push_end();
    push_text("(A+b)*c^d-Z/z");
    push_end();
    push_text(")x");
    push_end();
    push_text("(A");
    push_end();
    push_char(8'h00);
    push_char(8'hff);
    push_end();
    run_script();

    while (requests_sent < ITEM_TARGET) begin
      steady = ($urandom_range(0, 4) == 0);
      pick   = $urandom_range(0, 99);
      if (pick < 65)      build_expr();
      else if (pick < 78) build_broken();
      else if (pick < 90) build_nested();
      else                build_noise();
      run_script();
      exprs++;
    end
    in_valid <= 1'b0;
    steady = 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_q.size()));

    $display("covered %0d random sequences, %0d requests (%0d acted on), %0d results",
             exprs, requests_sent, sb.live_items, sb.checked);
    $display("results by status: %0d ok, %0d bad char, %0d unbalanced, %0d overflow",
             sb.by_status[STAT_OK], sb.by_status[STAT_BAD_CHAR],
             sb.by_status[STAT_UNBALANCED], sb.by_status[STAT_OVERFLOW]);
    if (sb.errors == 0)
      $display("infix_to_postfix_converter: match");
    else
      $display("infix_to_postfix_converter: mismatch");
    $finish;
  end

endmodule

>>> filelist.f
sv/i2p_pkg.sv
sv/i2p_stack_cell.sv
sv/i2p_op_stack.sv
sv/infix_to_postfix_converter.sv
sv/i2p_checker.sv
sim/tb_top.sv
